@@ src/odd_desc_even_asc_sorter_unit_defines.svh @@
// assertion macros for the odd-descending / even-ascending sorter
// used by the port checker; no other dependencies
`ifndef ODD_DESC_EVEN_ASC_SORTER_UNIT_DEFINES_SVH
`define ODD_DESC_EVEN_ASC_SORTER_UNIT_DEFINES_SVH

// implication checked on every edge outside reset
`define OSU_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// condition that must never be seen outside reset
`define OSU_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

@@ src/oddsort_pkg.sv @@
// shared types, constants and the ordering function of the sorter
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package oddsort_pkg;

  localparam int unsigned MAX_ITEMS_DEF = 64;
  localparam int unsigned ValW = 31;

  typedef logic [ValW-1:0] value_t;

  typedef enum logic {
    PH_LOAD,
    PH_DRAIN
  } phase_e;

  // what one cell shows its neighbors
  typedef struct packed {
    logic   valid;
    value_t value;
    logic   hit;
  } link_t;

  localparam link_t LINK_NONE = '{valid: 1'b0, value: '0, hit: 1'b0};

  // true if a is emitted before b: odd before even, odd descending, even ascending
  function automatic logic goes_before(value_t a, value_t b);
    logic res;
    if (a[0] != b[0]) begin
      res = a[0];
    end else if (a[0]) begin
      res = (a > b);
    end else begin
      res = (a < b);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

@@ src/oddsort_if.sv @@
// valid/ready channel interfaces of the sorter: element input and sorted output
// depends on oddsort_pkg
`timescale 1ns / 1ps
`default_nettype none

interface oddsort_in_if;
  logic                  valid;
  logic                  ready;
  oddsort_pkg::value_t   value;
  logic                  last;

  modport source (output valid, output value, output last, input ready);
  modport sink (input valid, input value, input last, output ready);
endinterface

interface oddsort_out_if;
  logic                  valid;
  logic                  ready;
  oddsort_pkg::value_t   sorted_value;
  logic                  last_out;
  logic                  overflow;

  modport source (output valid, output sorted_value, output last_out, output overflow,
                  input ready);
  modport sink (input valid, input sorted_value, input last_out, input overflow,
                output ready);
endinterface

`default_nettype wire

@@ src/oddsort_cell.sv @@
// one slot of the insertion chain: holds one element, inserts or shifts
// depends on oddsort_pkg
`timescale 1ns / 1ps
`default_nettype none

module oddsort_cell (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                ins_en_i,
  input  wire oddsort_pkg::value_t ins_value_i,
  input  wire logic                shift_i,
  input  wire oddsort_pkg::link_t  left_i,
  input  wire oddsort_pkg::link_t  right_i,
  output oddsort_pkg::link_t       link_o
);

  logic                valid_q, valid_d;
  oddsort_pkg::value_t value_q, value_d;
  logic                hit;

  // new element lands in the first empty slot or ahead of the first it precedes
  assign hit    = !valid_q || oddsort_pkg::goes_before(ins_value_i, value_q);
  assign link_o = '{valid: valid_q, value: value_q, hit: hit};

  always_comb begin
    valid_d = valid_q;
    value_d = value_q;
    if (shift_i) begin
      valid_d = right_i.valid;
      value_d = right_i.value;
    end else if (ins_en_i) begin
      if (left_i.hit) begin
        valid_d = left_i.valid;
        value_d = left_i.value;
      end else if (hit) begin
        valid_d = 1'b1;
        value_d = ins_value_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

endmodule

`default_nettype wire

@@ src/odd_desc_even_asc_sorter_unit.sv @@
// top level of the odd-descending / even-ascending set sorter
// depends on oddsort_pkg, oddsort_if and oddsort_cell
//
// usage:
//   in_i  (sink)   : one element per transaction; last closes the set
//   out_o (source) : the sorted set, odd values descending then even ascending;
//                    last_out marks the final element, overflow marks a set
//                    from which elements beyond MAX_ITEMS were dropped
// timing:
//   while loading, one element is taken every cycle; each is placed into a
//   chain of MAX_ITEMS cells in the same cycle it arrives
//   the first sorted element appears the cycle after the closing transaction,
//   then one element per cycle while out_o.ready is high
//   in_i.ready is low for the whole output burst; the chain shifts toward
//   the output only when the head element is taken
// reset:
//   all cells empty, element count and overflow cleared, block ready to load
// stall:
//   a low out_o.ready simply holds the head element and the chain
`timescale 1ns / 1ps
`default_nettype none

module odd_desc_even_asc_sorter_unit #(
  parameter int unsigned MAX_ITEMS = oddsort_pkg::MAX_ITEMS_DEF
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  oddsort_in_if.sink   in_i,
  oddsort_out_if.source out_o
);

  localparam int unsigned CntW = $clog2(MAX_ITEMS + 1);

  oddsort_pkg::phase_e phase_q, phase_d;
  logic [CntW-1:0]     count_q, count_d;
  logic                ovf_q, ovf_d;

  logic in_acc;
  logic out_acc;
  logic full;
  logic ins_en;
  logic shift;

  oddsort_pkg::link_t links [MAX_ITEMS];

  assign full    = (count_q == CntW'(MAX_ITEMS));
  assign in_acc  = in_i.valid && in_i.ready;
  assign out_acc = out_o.valid && out_o.ready;
  // an element that finds the chain full is dropped
  assign ins_en  = in_acc && !full;
  assign shift   = out_acc;

  // insertion chain, head at cell 0
  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    oddsort_pkg::link_t left, right;
    if (i == 0) begin : g_head
      assign left = oddsort_pkg::LINK_NONE;
    end else begin : g_mid
      assign left = links[i-1];
    end
    if (i == MAX_ITEMS - 1) begin : g_tail
      assign right = oddsort_pkg::LINK_NONE;
    end else begin : g_body
      assign right = links[i+1];
    end

    oddsort_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ins_en_i    (ins_en),
      .ins_value_i (in_i.value),
      .shift_i     (shift),
      .left_i      (left),
      .right_i     (right),
      .link_o      (links[i])
    );
  end

  // ports
  assign in_i.ready         = (phase_q == oddsort_pkg::PH_LOAD);
  assign out_o.valid        = (phase_q == oddsort_pkg::PH_DRAIN) && links[0].valid;
  assign out_o.sorted_value = links[0].value;
  assign out_o.last_out     = !links[1].valid;
  assign out_o.overflow     = ovf_q;

  // phase control, element count and overflow
  always_comb begin
    phase_d = phase_q;
    count_d = count_q;
    ovf_d   = ovf_q;
    unique case (phase_q)
      oddsort_pkg::PH_LOAD: begin
        if (in_acc) begin
          if (full) begin
            ovf_d = 1'b1;
          end else begin
            count_d = count_q + CntW'(1);
          end
          if (in_i.last) begin
            phase_d = oddsort_pkg::PH_DRAIN;
          end
        end
      end
      oddsort_pkg::PH_DRAIN: begin
        // the head leaving with nothing behind it ends the burst
        if (out_acc && !links[1].valid) begin
          phase_d = oddsort_pkg::PH_LOAD;
          count_d = '0;
          ovf_d   = 1'b0;
        end
      end
      default: begin
        phase_d = oddsort_pkg::PH_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= oddsort_pkg::PH_LOAD;
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else begin
      phase_q <= phase_d;
      count_q <= count_d;
      ovf_q   <= ovf_d;
    end
  end

endmodule

`default_nettype wire

@@ src/oddsort_checker.sv @@
// port-level checks of the sorter, attached to the top level by bind
// depends on odd_desc_even_asc_sorter_unit_defines.svh
`timescale 1ns / 1ps
`default_nettype none
`include "odd_desc_even_asc_sorter_unit_defines.svh"

module oddsort_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_ready_i,
  input wire logic out_valid_i,
  input wire logic out_ready_i,
  input wire logic out_last_i,
  input wire logic out_ovf_i
);

  // loading and emitting never overlap
  `OSU_ASSERT_NEVER(a_load_drain_excl, clk_i, rst_ni, in_ready_i && out_valid_i, "ready during burst")

  // a stalled result stays offered
  `OSU_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i |=> out_valid_i, "result dropped")

  // the burst ends right after the flagged last transaction
  `OSU_ASSERT(a_burst_end, clk_i, rst_ni, out_valid_i && out_ready_i && out_last_i |=> !out_valid_i && in_ready_i, "burst did not end")

  // inside a burst the next result follows with the same overflow flag
  `OSU_ASSERT(a_burst_cont, clk_i, rst_ni, out_valid_i && out_ready_i && !out_last_i |=> out_valid_i && (out_ovf_i == $past(out_ovf_i)), "burst broken")

endmodule

bind odd_desc_even_asc_sorter_unit oddsort_checker u_oddsort_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_last_i  (out_o.last_out),
  .out_ovf_i   (out_o.overflow)
);

`default_nettype wire
